// File: rtl/smi_pkg.sv
// shared index tables for the small matrix inverse pipeline
`default_nettype none
package smi_pkg;

  // operand pairs of the eighteen cofactor products, cofactor k = p[2k] - p[2k+1]
  localparam logic [3:0] PROD_A [18] = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2,
                                         4'd5, 4'd3, 4'd0, 4'd2, 4'd2, 4'd0,
                                         4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] PROD_B [18] = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4,
                                         4'd6, 4'd8, 4'd8, 4'd6, 4'd3, 4'd5,
                                         4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  // lane of the embedded 3x3 that feeds each output of a 2x2 result
  localparam logic [3:0] LANE2 [4] = '{4'd0, 4'd1, 4'd3, 4'd4};

  // matrix order codes
  localparam logic [1:0] ORDER_NONE = 2'd0;
  localparam logic [1:0] ORDER_ONE  = 2'd1;
  localparam logic [1:0] ORDER_TWO  = 2'd2;

endpackage
`default_nettype wire

// File: rtl/small_matrix_inverse.sv
// small matrix inverse by adjugate over determinant, fully pipelined
//
//  channel | ports          | tdata (low bit up)          | tuser (low bit up)
//  in      | in_t*          | in_0 .. in_8                | size
//  out     | out_t*         | out_0 .. out_8              | singular, saturated
//
// one matrix accepted per cycle unless out_tready stalls; the bit-per-stage restoring
// divider computes one quotient bit per stage in nine lanes.
// 1x1 and 2x2 matrices are embedded in a 3x3 with ones on the free diagonal.
// reset clears the valid bits only; data registers are not reset.
// a stall on out_tready freezes every stage together and drops in_tready.
`default_nettype none
module small_matrix_inverse #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // in_0, in_1, ... in_8
  input  wire logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] in_tdata,
  // size
  input  wire logic [1:0]                   in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // out_0, out_1, ... out_8
  output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] out_tdata,
  // singular, saturated
  output logic [1:0]                        out_tuser
);
  import smi_pkg::*;

  localparam int W   = ENTRY_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int TDW = ((9*W+7)/8)*8;
  localparam int PW  = 2*W;
  localparam int CFW = 2*W+1;
  localparam int TW  = 3*W+1;
  localparam int DW  = 3*W+3;
  localparam int CW  = 4*W+2*F+5;
  localparam int QW  = W+1;
  localparam int NS  = W+2;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: embed the matrix into a 3x3
  logic                 v0_r;
  logic [1:0]           sz0_r;
  logic [W-1:0]         raw0_r [9];
  logic signed [W-1:0]  m0_r [9];
  logic signed [W-1:0]  m0_nxt [9];

  always_comb begin
    for (int k = 0; k < 9; k++) m0_nxt[k] = '0;
    case (in_tuser)
      ORDER_ONE: begin
        m0_nxt[0] = in_tdata[0 +: W];
        m0_nxt[4] = W'(1);
        m0_nxt[8] = W'(1);
      end
      ORDER_TWO: begin
        m0_nxt[0] = in_tdata[0 +: W];
        m0_nxt[1] = in_tdata[W +: W];
        m0_nxt[3] = in_tdata[2*W +: W];
        m0_nxt[4] = in_tdata[3*W +: W];
        m0_nxt[8] = W'(1);
      end
      default: begin
        for (int k = 0; k < 9; k++) m0_nxt[k] = in_tdata[k*W +: W];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
    if (en) begin
      sz0_r <= in_tuser;
      for (int k = 0; k < 9; k++) begin
        raw0_r[k] <= in_tdata[k*W +: W];
        m0_r[k]   <= m0_nxt[k];
      end
    end
  end

  // stage 1: eighteen entry products
  logic                 v1_r;
  logic [1:0]           sz1_r;
  logic [W-1:0]         raw1_r [9];
  logic signed [PW-1:0] p1_r [18];
  logic signed [W-1:0]  ma1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
    if (en) begin
      sz1_r <= sz0_r;
      for (int k = 0; k < 9; k++) raw1_r[k] <= raw0_r[k];
      for (int k = 0; k < 18; k++) p1_r[k] <= m0_r[PROD_A[k]] * m0_r[PROD_B[k]];
      for (int k = 0; k < 3; k++) ma1_r[k] <= m0_r[k];
    end
  end

  // stage 2: cofactors
  logic                  v2_r;
  logic [1:0]            sz2_r;
  logic [W-1:0]          raw2_r [9];
  logic signed [CFW-1:0] cof2_r [9];
  logic signed [W-1:0]   ma2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      sz2_r <= sz1_r;
      for (int k = 0; k < 9; k++) begin
        raw2_r[k] <= raw1_r[k];
        cof2_r[k] <= CFW'(p1_r[2*k]) - CFW'(p1_r[2*k+1]);
      end
      for (int k = 0; k < 3; k++) ma2_r[k] <= ma1_r[k];
    end
  end

  // stage 3: determinant partial products, cofactor split in low and high halves
  logic                  v3_r;
  logic [1:0]            sz3_r;
  logic [W-1:0]          raw3_r [9];
  logic signed [CFW-1:0] cof3_r [9];
  logic signed [CFW-1:0] plo3_r [3];
  logic signed [CFW-1:0] phi3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      sz3_r <= sz2_r;
      for (int k = 0; k < 9; k++) begin
        raw3_r[k] <= raw2_r[k];
        cof3_r[k] <= cof2_r[k];
      end
      for (int t = 0; t < 3; t++) begin
        plo3_r[t] <= ma2_r[t] * $signed({1'b0, cof2_r[3*t][W-1:0]});
        phi3_r[t] <= ma2_r[t] * $signed(cof2_r[3*t][CFW-1:W]);
      end
    end
  end

  // stage 4: recombine each determinant term
  logic                  v4_r;
  logic [1:0]            sz4_r;
  logic [W-1:0]          raw4_r [9];
  logic signed [CFW-1:0] cof4_r [9];
  logic signed [TW-1:0]  term4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      sz4_r <= sz3_r;
      for (int k = 0; k < 9; k++) begin
        raw4_r[k] <= raw3_r[k];
        cof4_r[k] <= cof3_r[k];
      end
      for (int t = 0; t < 3; t++)
        term4_r[t] <= (TW'(phi3_r[t]) <<< W) + TW'(plo3_r[t]);
    end
  end

  // stage 5: determinant
  logic                  v5_r;
  logic [1:0]            sz5_r;
  logic [W-1:0]          raw5_r [9];
  logic signed [CFW-1:0] cof5_r [9];
  logic signed [DW-1:0]  det5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      sz5_r <= sz4_r;
      for (int k = 0; k < 9; k++) begin
        raw5_r[k] <= raw4_r[k];
        cof5_r[k] <= cof4_r[k];
      end
      det5_r <= DW'(term4_r[0]) + DW'(term4_r[1]) + DW'(term4_r[2]);
    end
  end

  // divider stage arrays, index 0 is the setup stage
  logic            dv_r    [NS];
  logic [1:0]      dsz_r   [NS];
  logic            dsing_r [NS];
  logic [W-1:0]    draw_r  [NS][9];
  logic [CW-1:0]   dmag_r  [NS];
  logic [CW-1:0]   drem_r  [NS][9];
  logic [QW-1:0]   dq_r    [NS][9];
  logic            dneg_r  [NS][9];
  logic            dover_r [NS][9];

  // setup: magnitudes, signs and the out-of-range check
  logic signed [CW-1:0] detx, cofx;
  logic [CW-1:0]        dmag_nxt;
  logic [CW-1:0]        num_nxt [9];
  logic                 neg_nxt [9];
  logic                 over_nxt [9];

  always_comb begin
    detx     = CW'(det5_r);
    dmag_nxt = det5_r[DW-1] ? CW'(-detx) : CW'(detx);
    for (int k = 0; k < 9; k++) begin
      cofx        = CW'(cof5_r[k]);
      num_nxt[k]  = (cof5_r[k][CFW-1] ? CW'(-cofx) : CW'(cofx)) << (2*F);
      neg_nxt[k]  = cof5_r[k][CFW-1] ^ det5_r[DW-1];
      over_nxt[k] = num_nxt[k] >= (dmag_nxt << (W+1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= v5_r;
    if (en) begin
      dsz_r[0]   <= sz5_r;
      dsing_r[0] <= (det5_r == '0) || (sz5_r == ORDER_NONE);
      dmag_r[0]  <= dmag_nxt;
      for (int k = 0; k < 9; k++) begin
        draw_r[0][k]  <= raw5_r[k];
        drem_r[0][k]  <= num_nxt[k];
        dq_r[0][k]    <= '0;
        dneg_r[0][k]  <= neg_nxt[k];
        dover_r[0][k] <= over_nxt[k];
      end
    end
  end

  // restoring divider, one quotient bit per stage from bit W down
  for (genvar j = 0; j < W+1; j++) begin : g_div
    localparam int B = W - j;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else if (en) dv_r[j+1] <= dv_r[j];
      if (en) begin
        dsz_r[j+1]   <= dsz_r[j];
        dsing_r[j+1] <= dsing_r[j];
        dmag_r[j+1]  <= dmag_r[j];
        for (int k = 0; k < 9; k++) begin
          draw_r[j+1][k]  <= draw_r[j][k];
          dneg_r[j+1][k]  <= dneg_r[j][k];
          dover_r[j+1][k] <= dover_r[j][k];
          if (drem_r[j][k] >= (dmag_r[j] << B)) begin
            drem_r[j+1][k] <= drem_r[j][k] - (dmag_r[j] << B);
            dq_r[j+1][k]   <= dq_r[j][k] | (QW'(1) << B);
          end else begin
            drem_r[j+1][k] <= drem_r[j][k];
            dq_r[j+1][k]   <= dq_r[j][k];
          end
        end
      end
    end
  end

  // saturation and sign per lane
  logic [W-1:0] res  [9];
  logic         lsat [9];
  logic [QW-1:0] qm;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qm = dq_r[NS-1][k];
      if (dneg_r[NS-1][k]) begin
        lsat[k] = dover_r[NS-1][k] || (qm > (QW'(1) << (W-1)));
        if (lsat[k]) qm = QW'(1) << (W-1);
        res[k] = W'(-qm);
      end else begin
        lsat[k] = dover_r[NS-1][k] || qm[W] || qm[W-1];
        if (lsat[k]) qm = (QW'(1) << (W-1)) - QW'(1);
        res[k] = W'(qm);
      end
    end
  end

  // map lanes back to the flat outputs of the given order
  logic [TDW-1:0] odata_nxt;
  logic           osat_nxt;

  always_comb begin
    odata_nxt = '0;
    osat_nxt  = 1'b0;
    for (int o = 0; o < 9; o++) odata_nxt[o*W +: W] = draw_r[NS-1][o];
    if (!dsing_r[NS-1]) begin
      case (dsz_r[NS-1])
        ORDER_ONE: begin
          odata_nxt[0 +: W] = res[0];
          osat_nxt          = lsat[0];
        end
        ORDER_TWO: begin
          for (int o = 0; o < 4; o++) begin
            odata_nxt[o*W +: W] = res[LANE2[o]];
            osat_nxt            = osat_nxt | lsat[LANE2[o]];
          end
        end
        default: begin
          for (int o = 0; o < 9; o++) begin
            odata_nxt[o*W +: W] = res[o];
            osat_nxt            = osat_nxt | lsat[o];
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dv_r[NS-1];
    if (en) begin
      out_tdata <= odata_nxt;
      out_tuser <= {osat_nxt, dsing_r[NS-1]};
    end
  end

`ifndef ASSERT_OFF
  // a singular result never reports saturation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("singular result flagged as saturated");

  // input is held off only by a waiting, untaken result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // a stalled result reaches the next cycle unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
